[rtl/core/cse_pkg.sv]
`default_nettype none
package cse_pkg;
  localparam int MaxSegmentsDefault = 64;
  localparam int FracBitsDefault = 16;
  localparam int CountW = 7;
  localparam int SlotW = 6;
  localparam int DataW = 32;

  typedef enum logic [1:0] {
    RS_IN_RANGE = 2'd0,
    RS_BELOW    = 2'd1,
    RS_ABOVE    = 2'd2,
    RS_EMPTY    = 2'd3
  } range_status_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BOUND, ST_CHECK, ST_SEARCH, ST_SREAD, ST_COEF, ST_DELTA,
    ST_MUL, ST_ADD, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic wr;
    logic rd_first;
    logic rd_last;
    logic rd_mid;
    logic search_step;
    logic rd_coef;
    logic calc_delta;
    logic mul;
    logic add;
    logic set_status;
    logic out_load;
  } cse_cmd_t;

  typedef struct packed {
    logic is_eval;
    logic empty;
    logic below;
    logic above;
    logic search_done;
    logic last_add;
  } cse_stat_t;
endpackage
`default_nettype wire

[rtl/core/cse_if.sv]
`default_nettype none
interface cse_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  segment_slot;
  logic signed [31:0] seg_start;
  logic signed [31:0] seg_end;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [31:0] coef_c;
  logic signed [31:0] coef_d;
  logic signed [31:0] x_value;
  modport source (output valid, cmd, segment_slot, seg_start, seg_end, coef_a, coef_b,
                  coef_c, coef_d, x_value, input ready);
  modport sink (input valid, cmd, segment_slot, seg_start, seg_end, coef_a, coef_b,
                coef_c, coef_d, x_value, output ready);
endinterface

interface cse_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] y_value;
  logic [1:0]  range_status;
  logic [5:0]  segment_index;
  logic        saturated;
  modport source (output valid, y_value, range_status, segment_index, saturated,
                  input ready);
  modport sink (input valid, y_value, range_status, segment_index, saturated,
                output ready);
endinterface
`default_nettype wire

[rtl/core/cse_ctrl.sv]
`default_nettype none
module cse_ctrl
  import cse_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire cse_stat_t stat,
  output cse_cmd_t       cmd
);
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_BOUND;
        end
      end
      ST_BOUND: begin
        if (!stat.is_eval) begin
          cmd.wr = 1'b1;
          cmd.set_status = 1'b1;
          state_nxt = ST_OUT;
        end else if (stat.empty) begin
          cmd.set_status = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          cmd.rd_first = 1'b1;
          cmd.rd_last = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.set_status = 1'b1;
        if (stat.below || stat.above) state_nxt = ST_OUT;
        else state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (stat.search_done) begin
          cmd.rd_coef = 1'b1;
          state_nxt = ST_COEF;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt = ST_SREAD;
        end
      end
      ST_SREAD: begin
        cmd.search_step = 1'b1;
        state_nxt = ST_SEARCH;
      end
      ST_COEF: state_nxt = ST_DELTA;
      ST_DELTA: begin
        cmd.calc_delta = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        state_nxt = stat.last_add ? ST_OUT : ST_MUL;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/cse_dp.sv]
`default_nettype none
module cse_dp
  import cse_pkg::*;
#(
  parameter int MAX_SEGMENTS = MaxSegmentsDefault,
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CountW-1:0] cfg_wr_data,
  input  wire logic              in_cmd,
  input  wire logic [SlotW-1:0]  in_segment_slot,
  input  wire logic [DataW-1:0]  in_seg_start,
  input  wire logic [DataW-1:0]  in_seg_end,
  input  wire logic [DataW-1:0]  in_coef_a,
  input  wire logic [DataW-1:0]  in_coef_b,
  input  wire logic [DataW-1:0]  in_coef_c,
  input  wire logic [DataW-1:0]  in_coef_d,
  input  wire logic [DataW-1:0]  in_x_value,
  input  wire cse_cmd_t          cmd,
  output cse_stat_t              stat,
  output logic [DataW-1:0]       out_y_value,
  output logic [1:0]             out_range_status,
  output logic [SlotW-1:0]       out_segment_index,
  output logic                   out_saturated
);
  localparam int IdxW = $clog2(MAX_SEGMENTS);
  localparam int NW = $clog2(MAX_SEGMENTS + 1);
  localparam logic signed [63:0] SMax = 64'sd2147483647;
  localparam logic signed [63:0] SMin = -64'sd2147483648;

  // start and end share one two-port array; coefficients a second one
  logic [2*DataW-1:0] se_mem [MAX_SEGMENTS];
  logic [4*DataW-1:0] cf_mem [MAX_SEGMENTS];

  logic [NW-1:0]  count_r;
  logic           cmd_r;
  logic [SlotW-1:0] slot_r;
  logic [DataW-1:0] st_r, en_r, a_r, b_r, c_r, d_r;
  logic signed [DataW-1:0] x_r;
  logic [2*DataW-1:0] rd0_r, rd1_r;
  logic [4*DataW-1:0] cf_r;
  logic [IdxW-1:0] lo_r, hi_r, mid_r;
  logic signed [DataW-1:0] delta_r, acc_r;
  logic signed [63:0] prod_r;
  logic [1:0] step_r;
  logic sat_r;
  logic [1:0] status_r;
  logic [IdxW-1:0] seg_r;
  logic [DataW-1:0] y_o_r;
  logic [1:0] st_o_r;
  logic [SlotW-1:0] seg_o_r;
  logic sat_o_r;

  logic [IdxW-1:0] last_idx, mid_nxt;
  logic signed [DataW-1:0] first_start, last_end, mid_start;
  logic signed [63:0] dwide, sh, sh_sat, addw, addend;
  logic signed [DataW-1:0] mul_a;
  logic [NW-1:0] cfg_clip;

  assign last_idx = IdxW'(count_r - NW'(1));
  assign first_start = rd0_r[2*DataW-1:DataW];
  assign last_end = rd1_r[DataW-1:0];
  assign mid_start = rd0_r[2*DataW-1:DataW];
  assign mid_nxt = IdxW'(({1'b0, lo_r} + {1'b0, hi_r} + 1'b1) >> 1);
  assign cfg_clip = (int'(cfg_wr_data) > MAX_SEGMENTS) ? NW'(MAX_SEGMENTS)
                                                       : NW'(cfg_wr_data);

  always_comb begin
    stat.is_eval = (cmd_r == CMD_EVAL);
    stat.empty = (count_r == '0);
    stat.below = x_r < first_start;
    stat.above = x_r > last_end;
    stat.search_done = !(lo_r < hi_r);
    stat.last_add = (step_r == 2'd2);
  end

  always_comb begin
    dwide = 64'(x_r) - 64'(signed'(st_r));
    sh = prod_r >>> FRAC_BITS;
    if (sh > SMax) sh_sat = SMax;
    else if (sh < SMin) sh_sat = SMin;
    else sh_sat = sh;
    unique case (step_r)
      2'd0: addend = 64'(signed'(cf_r[3*DataW-1:2*DataW]));
      2'd1: addend = 64'(signed'(cf_r[2*DataW-1:DataW]));
      default: addend = 64'(signed'(cf_r[DataW-1:0]));
    endcase
    mul_a = (step_r == 2'd0) ? signed'(cf_r[4*DataW-1:3*DataW]) : acc_r;
    addw = addend + sh_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cfg_wr_en) count_r <= cfg_clip;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      slot_r <= in_segment_slot;
      st_r <= in_seg_start;
      en_r <= in_seg_end;
      a_r <= in_coef_a;
      b_r <= in_coef_b;
      c_r <= in_coef_c;
      d_r <= in_coef_d;
      x_r <= signed'(in_x_value);
      sat_r <= 1'b0;
      seg_r <= '0;
      status_r <= RS_IN_RANGE;
    end
    if (cmd.wr && (int'(slot_r) < MAX_SEGMENTS)) begin
      se_mem[IdxW'(slot_r)] <= {st_r, en_r};
      cf_mem[IdxW'(slot_r)] <= {d_r, c_r, b_r, a_r};
    end
    if (cmd.rd_first) rd0_r <= se_mem['0];
    if (cmd.rd_last) rd1_r <= se_mem[last_idx];
    if (cmd.rd_mid) begin
      rd0_r <= se_mem[mid_nxt];
      mid_r <= mid_nxt;
    end
    if (cmd.rd_coef) begin
      cf_r <= cf_mem[lo_r];
      st_r <= se_mem[lo_r][2*DataW-1:DataW];
      seg_r <= lo_r;
    end
    if (cmd.set_status) begin
      lo_r <= '0;
      hi_r <= last_idx;
      step_r <= '0;
      acc_r <= '0;
      if (cmd_r != CMD_EVAL) status_r <= RS_IN_RANGE;
      else if (count_r == '0) status_r <= RS_EMPTY;
      else if (stat.below) status_r <= RS_BELOW;
      else if (stat.above) begin
        status_r <= RS_ABOVE;
        seg_r <= last_idx;
      end else status_r <= RS_IN_RANGE;
    end
    if (cmd.search_step) begin
      if (mid_start <= x_r) lo_r <= mid_r;
      else hi_r <= mid_r - 1'b1;
    end
    if (cmd.calc_delta) begin
      if (dwide > SMax) begin delta_r <= DataW'(SMax); sat_r <= 1'b1; end
      else if (dwide < SMin) begin delta_r <= DataW'(SMin); sat_r <= 1'b1; end
      else delta_r <= DataW'(dwide);
    end
    if (cmd.mul) prod_r <= 64'(mul_a) * 64'(delta_r);
    if (cmd.add) begin
      // saturate the shifted product, then the sum
      if (sh > SMax || sh < SMin || addw > SMax || addw < SMin) sat_r <= 1'b1;
      step_r <= step_r + 1'b1;
      if (addw > SMax) acc_r <= DataW'(SMax);
      else if (addw < SMin) acc_r <= DataW'(SMin);
      else acc_r <= DataW'(addw);
    end
    if (cmd.out_load) begin
      y_o_r <= (status_r == RS_IN_RANGE && cmd_r == CMD_EVAL) ? acc_r : '0;
      st_o_r <= status_r;
      seg_o_r <= SlotW'(seg_r);
      sat_o_r <= sat_r;
    end
  end

  assign out_y_value = y_o_r;
  assign out_range_status = st_o_r;
  assign out_segment_index = seg_o_r;
  assign out_saturated = sat_o_r;
endmodule
`default_nettype wire

[rtl/core/cubic_spline_segment_evaluator_unit.sv]
`default_nettype none
// Cubic spline segment evaluator. Write items (cmd 0) store one segment
// (start, end, a..d, Q16.16) into a slot; evaluate items (cmd 1) check x
// against the first start and the last end in use, binary-search the last
// segment whose start is at or below x, and return
// a + (b + (c + d*delta)*delta)*delta with flooring arithmetic shifts and 32-bit
// saturation. Each item gives exactly one result; a write returns all zero.
// One item is in flight at a time. An in-range evaluate runs a binary search,
// each step an address and then a compare on the registered read, and then
// three multiply/add rounds on the single shared multiplier. A result that
// waits on the output holds the next item in its last state. Table entries
// never written read as undefined. Write segment_count only while idle.
module cubic_spline_segment_evaluator_unit
  import cse_pkg::*;
#(
  parameter int MAX_SEGMENTS = MaxSegmentsDefault,
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CountW-1:0] cfg_wr_data,
  cse_in_if.sink                 in_ch,
  cse_out_if.source              out_ch
);
  cse_cmd_t  cmd;
  cse_stat_t stat;

  // controller: sequences load, bound check, search and Horner rounds
  cse_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  // datapath: tables, search registers, multiplier and output register
  cse_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_cmd(in_ch.cmd), .in_segment_slot(in_ch.segment_slot),
    .in_seg_start(in_ch.seg_start), .in_seg_end(in_ch.seg_end),
    .in_coef_a(in_ch.coef_a), .in_coef_b(in_ch.coef_b),
    .in_coef_c(in_ch.coef_c), .in_coef_d(in_ch.coef_d),
    .in_x_value(in_ch.x_value),
    .cmd, .stat,
    .out_y_value(out_ch.y_value), .out_range_status(out_ch.range_status),
    .out_segment_index(out_ch.segment_index), .out_saturated(out_ch.saturated)
  );
endmodule
`default_nettype wire

[tb/sv/tb_cubic_spline_segment_evaluator_unit.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_cubic_spline_segment_evaluator_unit;
  import cse_pkg::*;

  localparam int NumSeg = 64;
  localparam int Frac = 16;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  slot;
    logic [31:0] s_start;
    logic [31:0] s_end;
    logic [31:0] ca;
    logic [31:0] cb;
    logic [31:0] cc;
    logic [31:0] cd;
    logic [31:0] xq;
  } seg_item_t;

  typedef struct packed {
    logic [31:0]   y;
    range_status_t status;
    logic [5:0]    idx;
    logic          sat;
  } spline_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CountW-1:0] cfg_wr_data;

  cse_in_if in_ch();
  cse_out_if out_ch();

  cubic_spline_segment_evaluator_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Shadow copy of the segment table and the active count.
  longint tbl_start [NumSeg];
  longint tbl_end [NumSeg];
  longint tbl_a [NumSeg];
  longint tbl_b [NumSeg];
  longint tbl_c [NumSeg];
  longint tbl_d [NumSeg];
  int     active_segs;

  seg_item_t      pending_items[$];
  spline_result_t expected_results[$];
  int  fail_count;
  int  cycle_count;
  bit  stim_done;
  int  hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Append one item to the tail of the pending queue.
  function automatic void queue_item(input seg_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Append one prediction to the tail of the expected queue.
  function automatic void store_prediction(input spline_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Clip to signed 32 bits; raise the flag when clipped.
  function automatic longint clip32(input longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Fixed-point product with floor rescale and saturation.
  function automatic longint fx_product(input longint p, input longint q, inout bit flag);
    longint prod;
    prod = p * q;
    return clip32(prod >>> Frac, flag);
  endfunction

  // Apply one transfer to the shadow table and return its outcome.
  function automatic spline_result_t spline_outcome(input seg_item_t it);
    spline_result_t r;
    longint xq, delta, acc;
    int lo, hi, mid;
    bit flag;
    r = '0;
    r.status = RS_IN_RANGE;
    flag = 1'b0;
    if (it.cmd == CMD_WRITE) begin
      tbl_start[it.slot] = longint'($signed(it.s_start));
      tbl_end[it.slot] = longint'($signed(it.s_end));
      tbl_a[it.slot] = longint'($signed(it.ca));
      tbl_b[it.slot] = longint'($signed(it.cb));
      tbl_c[it.slot] = longint'($signed(it.cc));
      tbl_d[it.slot] = longint'($signed(it.cd));
      return r;
    end
    xq = longint'($signed(it.xq));
    if (active_segs == 0) begin
      r.status = RS_EMPTY;
    end else if (xq < tbl_start[0]) begin
      r.status = RS_BELOW;
    end else if (xq > tbl_end[active_segs-1]) begin
      r.status = RS_ABOVE;
      r.idx = 6'(active_segs - 1);
    end else begin
      lo = 0;
      hi = active_segs - 1;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (tbl_start[mid] <= xq) lo = mid;
        else hi = mid - 1;
      end
      r.idx = 6'(lo);
      delta = clip32(xq - tbl_start[lo], flag);
      acc = fx_product(tbl_d[lo], delta, flag);
      acc = clip32(tbl_c[lo] + acc, flag);
      acc = fx_product(acc, delta, flag);
      acc = clip32(tbl_b[lo] + acc, flag);
      acc = fx_product(acc, delta, flag);
      acc = clip32(tbl_a[lo] + acc, flag);
      r.y = acc[31:0];
    end
    r.sat = flag;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 8'hff)) - 128) <<< $urandom_range(0, 20);
      default: return $urandom();
    endcase
  endfunction

  function automatic seg_item_t write_item(input int slot, input longint st, input longint en);
    seg_item_t it;
    it.cmd = CMD_WRITE;
    it.slot = 6'(slot);
    it.s_start = st[31:0];
    it.s_end = en[31:0];
    it.ca = rand_word();
    it.cb = rand_word();
    it.cc = rand_word();
    it.cd = rand_word();
    it.xq = $urandom();
    return it;
  endfunction

  function automatic seg_item_t eval_item(input longint xq);
    seg_item_t it;
    it = write_item($urandom_range(0, 63), $urandom(), $urandom());
    it.cmd = CMD_EVAL;
    it.xq = xq[31:0];
    return it;
  endfunction

  // Driver: pop pending items, hold valid until the transfer, then send the next back to back or idle a random gap.
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (in_ch.valid && in_ch.ready) begin
      if (send_gap == 0 && pending_items.size() > 0 && $urandom_range(0, 4) == 0) begin
        {in_ch.cmd, in_ch.segment_slot, in_ch.seg_start, in_ch.seg_end, in_ch.coef_a,
         in_ch.coef_b, in_ch.coef_c, in_ch.coef_d, in_ch.x_value} <= pending_items.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
        send_gap <= $urandom_range(0, 4);
      end
    end else if (!in_ch.valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.cmd, in_ch.segment_slot, in_ch.seg_start, in_ch.seg_end, in_ch.coef_a,
         in_ch.coef_b, in_ch.coef_c, in_ch.coef_d, in_ch.x_value} <= pending_items.pop_front();
      end
    end
  end

  // Predict at each accepted input transfer.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      store_prediction(spline_outcome({in_ch.cmd, in_ch.segment_slot,
        in_ch.seg_start, in_ch.seg_end, in_ch.coef_a, in_ch.coef_b, in_ch.coef_c,
        in_ch.coef_d, in_ch.x_value}));
    end
  end

  // Monitor: random receiver stalls plus a long hold-off when requested.
  int recv_gap;
  always @(posedge clk) begin
    spline_result_t got, want;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.y_value, range_status_t'(out_ch.range_status),
               out_ch.segment_index, out_ch.saturated};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: expected y=%h st=%0d idx=%0d sat=%0b, actual y=%h st=%0d idx=%0d sat=%0b",
                     $time, want.y, want.status, want.idx, want.sat,
                     got.y, got.status, got.idx, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        recv_gap <= $urandom_range(0, 4);
        out_ch.ready <= ($urandom_range(0, 1) == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Drain everything in flight, then allow the block to settle.
  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_count(input int n);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 7'(n);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_segs = (n > NumSeg) ? NumSeg : n;
  endtask

  // Fill slots 0..n-1 with sorted segments and random coefficients.
  task automatic load_sorted(input int n, input longint base, input longint span);
    longint st;
    st = base;
    for (int i = 0; i < n; i++) begin
      queue_item(write_item(i, st, st + span - 1));
      st = st + span;
    end
  endtask

  // Mostly queries inside the loaded range, some outside and at the edges.
  task automatic random_evals(input int count);
    longint lo_x, hi_x, xq;
    lo_x = tbl_start[0];
    hi_x = tbl_end[active_segs-1];
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: xq = lo_x - $urandom_range(1, 1000);
        1: xq = hi_x + $urandom_range(1, 1000);
        2: xq = $signed($urandom());
        3: xq = tbl_start[$urandom_range(0, active_segs-1)];
        default: xq = lo_x + longint'($urandom()) % (hi_x - lo_x + 1);
      endcase
      if (xq > 64'sd2147483647) xq = 64'sd2147483647;
      if (xq < -64'sd2147483648) xq = -64'sd2147483648;
      queue_item(eval_item(xq));
    end
  endtask

  initial begin
    int n;
    longint span;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    {in_ch.cmd, in_ch.segment_slot, in_ch.seg_start, in_ch.seg_end, in_ch.coef_a,
     in_ch.coef_b, in_ch.coef_c, in_ch.coef_d, in_ch.x_value} = '0;
    out_ch.ready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    stim_done = 1'b0;
    hold_off_cycles = 0;
    active_segs = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: every query reports empty.
    queue_item(eval_item(0));
    queue_item(eval_item(-64'sd2147483648));
    queue_item(eval_item(64'sd2147483647));
    // Two segments with extreme coefficients, sorted starts.
    begin
      seg_item_t it;
      it = write_item(0, -64'sd2147483648, 0);
      it.ca = 32'h7fffffff; it.cb = 32'h7fffffff; it.cc = 32'h7fffffff; it.cd = 32'h7fffffff;
      queue_item(it);
      it = write_item(1, 1, 64'sd2147483647);
      it.ca = 32'h80000000; it.cb = 32'h80000000; it.cc = 32'h80000000; it.cd = 32'h80000000;
      queue_item(it);
      it = write_item(63, 0, 0);
      it.slot = 6'h3f;
      queue_item(it);
    end
    set_count(2);
    // Wide delta, boundaries and a query on each side.
    queue_item(eval_item(64'sd2147483647));
    queue_item(eval_item(-64'sd2147483648));
    queue_item(eval_item(0));
    queue_item(eval_item(1));
    // Gap and above-maximum case with a narrower last end.
    queue_item(write_item(1, 100, 200));
    queue_item(eval_item(50));
    queue_item(eval_item(150));
    queue_item(eval_item(201));
    // Overlapping segments: search still lands somewhere.
    queue_item(write_item(1, -500, 200));
    queue_item(eval_item(-100));
    queue_item(eval_item(-600));
    // Counts written above the maximum are clipped.
    set_count(0);
    queue_item(eval_item(5));
    load_sorted(64, -64'sd2147483648, 64'sd67108864);
    set_count(127);
    queue_item(eval_item(-64'sd2147483648));
    queue_item(eval_item(64'sd2147483647));

    // Random phases over several table sizes, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: n = 64;
        1: n = 1;
        2: n = 2;
        default: n = $urandom_range(1, 64);
      endcase
      span = (ph % 2) ? $urandom_range(1, 4096) : 64'sd65536 * $urandom_range(1, 1000);
      set_count(0);
      load_sorted(n, -(span * n) / 2 + $signed($urandom_range(0, 2000)) - 1000, span);
      // A stray write beyond the active range.
      if (n < 64) queue_item(write_item($urandom_range(n, 63), $urandom(), $urandom()));
      set_count(n);
      drain();
      if (ph == 3) hold_off_cycles = 400;
      random_evals(60);
    end
    drain();
    stim_done = 1'b1;
  end

  // End of run: clean finish or timeout.
  always @(posedge clk) begin
    if (stim_done) begin
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end
endmodule
`default_nettype wire
